[rtl/assert_macros.svh]
// Assertion helpers used by the RTL control module fsl_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_CLK_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/fsl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fsl_pkg;

  localparam int PN_BITS    = 128;
  localparam int BIT_CNT_W  = $clog2(PN_BITS);
  localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(PN_BITS - 1);

  localparam int KEY_W      = 24;
  localparam int FN_W       = 16;
  localparam int FN15_W     = 15;
  localparam int HALF_W     = 64;
  localparam int PAYLOAD_W  = 2 * HALF_W;

  localparam logic [FN15_W-1:0] SIG_FRAME_MIN = 15'h7FFC;
  localparam logic [PAYLOAD_W-1:0] MASK_INIT = PAYLOAD_W'(1) << (PAYLOAD_W - 1);

  // Tap set codes
  localparam logic [1:0] CLS_8  = 2'd0;
  localparam logic [1:0] CLS_16 = 2'd1;
  localparam logic [1:0] CLS_24 = 2'd2;

  typedef struct packed {
    logic             we;
    logic [KEY_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic load;
    logic upd_exp;
    logic seed_key;
    logic resync_start;
    logic resync_step;
    logic scr_step;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic need_resync;
    logic fn_zero;
    logic do_scr;
    logic bit_last;
    logic frm_zero;
  } dp_sts_t;

  function automatic logic [1:0] width_class(input logic [KEY_W-1:0] k);
    logic [1:0] c;
    if (k > 24'h00FFFF) begin
      c = CLS_24;
    end else if (k > 24'h0000FF) begin
      c = CLS_16;
    end else begin
      c = CLS_8;
    end
    return c;
  endfunction

  function automatic logic lfsr_fb(input logic [1:0] cls, input logic [KEY_W-1:0] s);
    logic b;
    unique case (cls)
      CLS_24:  b = s[23] ^ s[22] ^ s[21] ^ s[16];
      CLS_16:  b = s[15] ^ s[14] ^ s[12] ^ s[3];
      default: b = s[7] ^ s[5] ^ s[4] ^ s[3];
    endcase
    return b;
  endfunction

  function automatic logic [KEY_W-1:0] lfsr_adv(input logic [1:0] cls,
                                                input logic [KEY_W-1:0] s);
    return {s[KEY_W-2:0], lfsr_fb(cls, s)};
  endfunction

  function automatic logic [KEY_W-1:0] seed_trunc(input logic [1:0] cls,
                                                  input logic [KEY_W-1:0] s);
    logic [KEY_W-1:0] r;
    unique case (cls)
      CLS_24:  r = s;
      CLS_16:  r = {8'd0, s[15:0]};
      default: r = {16'd0, s[7:0]};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/fsl_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module fsl_datapath
  import fsl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cfg_wr_t              cfg_wr,
  input  wire dp_cmd_t              cmd,
  output dp_sts_t                   sts,
  input  wire logic [FN_W-1:0]      in_fn,
  input  wire logic                 in_sig,
  input  wire logic [PAYLOAD_W-1:0] in_payload,
  output logic [KEY_W-1:0]          key_value,
  output logic [PAYLOAD_W-1:0]      out_payload,
  output logic                      out_resynced
);

  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [KEY_W-1:0]     seed_r, seed_nxt;
  logic [FN15_W-1:0]    exp_r, exp_nxt;
  logic [FN_W-1:0]      fn_r;
  logic                 sig_r;
  logic [PAYLOAD_W-1:0] data_r;
  logic [PAYLOAD_W-1:0] mask_r;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [FN15_W-1:0]    frm_cnt_r;
  logic                 resync_r;
  logic [PAYLOAD_W-1:0] out_data_r;
  logic                 out_resync_r;

  logic [1:0]           cls;
  logic                 fb;
  logic [KEY_W-1:0]     seed_adv;

  assign cls      = width_class(key_r);
  assign fb       = lfsr_fb(cls, seed_r);
  assign seed_adv = lfsr_adv(cls, seed_r);

  assign sts.need_resync = (fn_r != '0) && (fn_r[FN15_W-1:0] != exp_r);
  assign sts.fn_zero     = (fn_r == '0);
  assign sts.do_scr      = !sig_r || (fn_r[FN15_W-1:0] < SIG_FRAME_MIN);
  assign sts.bit_last    = (bit_cnt_r == BIT_LAST);
  assign sts.frm_zero    = (frm_cnt_r == '0);

  assign key_value    = key_r;
  assign out_payload  = out_data_r;
  assign out_resynced = out_resync_r;

  always_comb begin
    key_nxt     = key_r;
    seed_nxt    = seed_r;
    exp_nxt     = exp_r;
    bit_cnt_nxt = bit_cnt_r;
    if (cfg_wr.we) begin
      key_nxt  = cfg_wr.data;
      seed_nxt = cfg_wr.data;
    end
    priority if (cmd.seed_key) begin
      seed_nxt = key_r;
    end else if (cmd.resync_step) begin
      seed_nxt = seed_adv;
    end else if (cmd.scr_step) begin
      // trim the seed to the tap width after the last step of a frame
      seed_nxt = sts.bit_last ? seed_trunc(cls, seed_adv) : seed_adv;
    end else begin
      seed_nxt = seed_nxt;
    end
    if (cmd.upd_exp) begin
      exp_nxt = FN15_W'(fn_r + FN_W'(1));
    end
    if (cmd.load || cmd.resync_start) begin
      bit_cnt_nxt = '0;
    end else if (cmd.resync_step || cmd.scr_step) begin
      bit_cnt_nxt = sts.bit_last ? '0 : bit_cnt_r + BIT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      seed_r    <= '0;
      exp_r     <= '0;
      bit_cnt_r <= '0;
    end else begin
      key_r     <= key_nxt;
      seed_r    <= seed_nxt;
      exp_r     <= exp_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fn_r     <= in_fn;
      sig_r    <= in_sig;
      data_r   <= in_payload;
      mask_r   <= MASK_INIT;
      resync_r <= 1'b0;
    end else if (cmd.scr_step) begin
      // apply the PN bit at the marked position, then move the mark down
      data_r <= data_r ^ (mask_r & {PAYLOAD_W{fb}});
      mask_r <= mask_r >> 1;
    end
    if (cmd.resync_start) begin
      frm_cnt_r <= fn_r[FN15_W-1:0];
      resync_r  <= 1'b1;
    end else if (cmd.resync_step && sts.bit_last) begin
      frm_cnt_r <= frm_cnt_r - FN15_W'(1);
    end
    if (cmd.push) begin
      out_data_r   <= data_r;
      out_resync_r <= resync_r;
    end
  end

endmodule
`default_nettype wire

[rtl/fsl_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fsl_ctrl
  import fsl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_RESYNC = 3'd2;
  localparam logic [2:0] S_SCR    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.upd_exp = 1'b1;
        if (sts.need_resync) begin
          cmd.seed_key     = 1'b1;
          cmd.resync_start = 1'b1;
          state_nxt        = S_RESYNC;
        end else begin
          cmd.seed_key = sts.fn_zero;
          state_nxt    = sts.do_scr ? S_SCR : S_DONE;
        end
      end
      S_RESYNC: begin
        if (sts.frm_zero) begin
          state_nxt = sts.do_scr ? S_SCR : S_DONE;
        end else begin
          cmd.resync_step = 1'b1;
        end
      end
      S_SCR: begin
        cmd.scr_step = 1'b1;
        if (sts.bit_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_CLK_ALL(a_reset_clean, !rst_n |=> (state_r == S_IDLE) && !out_valid_r, "reset left control busy")
  `ASSERT_CLK(a_accept_eval, (in_tvalid && in_tready) |=> (state_r == S_EVAL), "accepted beat not evaluated")
  `ASSERT_CLK(a_scr_done, (state_r == S_SCR && sts.bit_last) |=> (state_r == S_DONE), "scramble overran its length")
  `ASSERT_CLK(a_resync_exit, (state_r == S_RESYNC && sts.frm_zero) |=> (state_r != S_RESYNC), "resync walk did not stop")

endmodule
`default_nettype wire

[rtl/frame_scrambler_lfsr.sv]
`timescale 1ns / 1ps
`default_nettype none
// Frame descrambler: one stream beat carries a frame number and a 128-bit payload, and one
// result beat returns the payload XORed with PN_BITS bits of a Fibonacci LFSR whose tap
// width (8, 16 or 24 bits) follows the magnitude of the key register. Writing the key also
// reloads the running seed. The LFSR advances one step per cycle while a frame is scrambled;
// a signature frame is passed through unchanged. When the frame number is not the expected
// one the seed is rebuilt from the key by walking the same LFSR, and that beat carries
// resynced = 1. The result sits in an output register, so a new beat is taken while it waits.
module frame_scrambler_lfsr
  import fsl_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // configuration port
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  // input stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [143:0] in_tdata,  // frame_number[15:0], payload_hi[79:16], payload_lo[143:80]
  input  wire logic         in_tuser,  // stream_signed
  // result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata, // data_out_hi[63:0], data_out_lo[127:64]
  output logic              out_tuser  // resynced
);

  localparam logic REG_KEY = 1'b0;

  cfg_wr_t              cfg_wr;
  dp_cmd_t              cmd;
  dp_sts_t              sts;
  logic [KEY_W-1:0]     key_value;
  logic [PAYLOAD_W-1:0] out_payload;
  logic                 reg_idx;

  assign reg_idx     = cfg_paddr[2];
  assign cfg_pready  = 1'b1;
  assign cfg_wr.we   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && (reg_idx == REG_KEY);
  assign cfg_wr.data = cfg_pwdata[KEY_W-1:0];

  always_comb begin
    unique case (reg_idx)
      REG_KEY: cfg_prdata = {8'd0, key_value};
      default: cfg_prdata = '0;
    endcase
  end

  fsl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  fsl_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr       (cfg_wr),
    .cmd          (cmd),
    .sts          (sts),
    .in_fn        (in_tdata[15:0]),
    .in_sig       (in_tuser),
    .in_payload   ({in_tdata[79:16], in_tdata[143:80]}),
    .key_value    (key_value),
    .out_payload  (out_payload),
    .out_resynced (out_tuser)
  );

  assign out_tdata = {out_payload[HALF_W-1:0], out_payload[PAYLOAD_W-1:HALF_W]};

endmodule
`default_nettype wire
